@@ src/wlrgb_pkg.sv @@
// Shared constants, types and the exponential table builder for the
// wavelength to linear RGB pipeline. No dependencies.
`timescale 1ns / 1ps

package wlrgb_pkg;

  localparam int unsigned WL_W      = 14;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned POS_W     = 17;   // 10 * wavelength, 1/160 nm
  localparam int unsigned NUM_LOBES = 7;
  localparam int unsigned U_W       = 28;   // exponent argument, Q24 below 16
  localparam int unsigned DIV_W     = 18;   // squared lobe width
  localparam int unsigned RCP_W     = 34;   // reciprocal of squared width
  localparam int unsigned WP_W      = 50;   // weighted lobe value, Q46
  localparam int unsigned LOBE_LAT  = 7;
  localparam int unsigned MIX_LAT   = 4;

  localparam int unsigned OUT_FRAC_BITS_DEF = 12;
  localparam int unsigned EXP_ADDR_BITS_DEF = 8;

  localparam logic [WL_W-1:0] WL_MIN = 14'd6080;   // 380 nm
  localparam logic [WL_W-1:0] WL_MAX = 14'd12480;  // 780 nm

  typedef logic [COLOR_W-1:0]       color_t;
  typedef logic signed [WP_W-1:0]   wp_t;

  // Lobes: x uses entries 0..2, y 3..4, z 5..6
  localparam int unsigned LOBE_CENTRE [NUM_LOBES] =
    '{95968, 70720, 80176, 91008, 84944, 69920, 73440};
  localparam int unsigned LOBE_LOWER [NUM_LOBES] =
    '{379, 160, 204, 469, 163, 118, 260};
  localparam int unsigned LOBE_UPPER [NUM_LOBES] =
    '{310, 267, 262, 405, 311, 360, 138};
  localparam int LOBE_WEIGHT [NUM_LOBES] =
    '{69206, 23724, -4260, 53805, 18743, 79757, 44630};

  // XYZ to linear sRGB, D65, signed Q16
  localparam int XYZ_TO_RGB [3][3] = '{
    '{212376, -100742, -32676},
    '{-63498, 122932, 2720},
    '{3650, -13369, 69272}
  };

  // Reciprocals of the channel means, Q16
  localparam int unsigned CHAN_RECIP [3] = '{149160, 227756, 240439};

  // exp(-2^e) in Q30 for e = -8 .. 4
  localparam logic [29:0] EXP_BIT [13] = '{
    30'd1069555703, 30'd1065385899, 30'd1057095014, 30'd1040706261,
    30'd1008687095, 30'd947573834, 30'd836230973, 30'd651257337,
    30'd395007542, 30'd145315154, 30'd19666267, 30'd360200, 30'd121
  };

  // Table entry k: product of exp(-2^e) for each set bit, rounded half up
  function automatic logic [30:0] exp_rom_entry(input int unsigned k,
                                                input int unsigned addr_bits);
    logic [63:0] acc;
    acc = 64'd1 << 30;
    for (int unsigned i = 0; i <= addr_bits; i++) begin
      if (((k >> i) & 1) != 0) begin
        acc = (acc * 64'(EXP_BIT[12 - addr_bits + i]) + (64'd1 << 29)) >> 30;
      end
    end
    return acc[30:0];
  endfunction

endpackage

@@ src/wlrgb_if.sv @@
// Valid/ready stream interfaces for the wavelength input and RGB result.
// Depends on wlrgb_pkg.
`timescale 1ns / 1ps

interface wlrgb_in_if import wlrgb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [WL_W-1:0] wavelength;

  modport source (output valid, output wavelength, input ready);
  modport sink   (input valid, input wavelength, output ready);
endinterface

interface wlrgb_out_if import wlrgb_pkg::*; ();
  logic   valid;
  logic   ready;
  color_t red;
  color_t green;
  color_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ src/wlrgb_lobe.sv @@
// One asymmetric Gaussian lobe: distance, exact division by the squared
// width, table exponential with interpolation, weighting. Depends on wlrgb_pkg.
`timescale 1ns / 1ps

module wlrgb_lobe import wlrgb_pkg::*; #(
  parameter int unsigned LOBE_IDX            = 0,
  parameter int unsigned EXP_TABLE_ADDR_BITS = EXP_ADDR_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [POS_W-1:0] pos,
  output wp_t              wp
);

  localparam int unsigned AB        = EXP_TABLE_ADDR_BITS;
  localparam int unsigned FB        = U_W - AB;
  localparam int unsigned ROM_DEPTH = (1 << AB) + 1;
  localparam int unsigned SQ_W      = 2 * POS_W;
  localparam int unsigned NUM_W     = SQ_W + 15;
  localparam int unsigned IW        = FB + 34;

  localparam longint unsigned S_LO = longint'(LOBE_LOWER[LOBE_IDX]);
  localparam longint unsigned S_HI = longint'(LOBE_UPPER[LOBE_IDX]);
  localparam logic [DIV_W-1:0] D_LO = DIV_W'(S_LO * S_LO);
  localparam logic [DIV_W-1:0] D_HI = DIV_W'(S_HI * S_HI);
  localparam logic [SQ_W-1:0]  LIM_LO = SQ_W'(S_LO * S_LO * 64'd8192);
  localparam logic [SQ_W-1:0]  LIM_HI = SQ_W'(S_HI * S_HI * 64'd8192);
  localparam logic [RCP_W-1:0] M_LO = RCP_W'((64'd1 << 46) / (S_LO * S_LO));
  localparam logic [RCP_W-1:0] M_HI = RCP_W'((64'd1 << 46) / (S_HI * S_HI));
  localparam logic signed [POS_W:0] CENTRE = (POS_W+1)'(LOBE_CENTRE[LOBE_IDX]);
  localparam logic signed [17:0]    WEIGHT = 18'(LOBE_WEIGHT[LOBE_IDX]);
  localparam logic [IW-1:0]         HALF   = IW'(1) << (FB - 1);

  logic [30:0] rom [ROM_DEPTH];

  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    assign rom[i] = exp_rom_entry(i, AB);
  end

  // stage 1: distance and square
  logic signed [POS_W:0] d;
  logic [POS_W-1:0]      ad;
  logic [SQ_W-1:0]       sq1_r;
  logic                  neg1_r;

  assign d  = $signed({1'b0, pos}) - CENTRE;
  assign ad = d[POS_W] ? POS_W'(-d) : d[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r  <= SQ_W'(ad) * SQ_W'(ad);
      neg1_r <= d[POS_W];
    end
  end

  // stage 2: tail test and quotient estimate (low by at most one)
  logic [2*SQ_W-1:0] est;
  logic [SQ_W-1:0]   sq2_r;
  logic [U_W-1:0]    q2_r;
  logic              neg2_r, far2_r;

  assign est = (2*SQ_W)'(sq1_r) * (2*SQ_W)'(neg1_r ? M_LO : M_HI);

  always_ff @(posedge clk) begin
    if (en) begin
      sq2_r  <= sq1_r;
      q2_r   <= est[31 +: U_W];
      neg2_r <= neg1_r;
      far2_r <= sq1_r >= (neg1_r ? LIM_LO : LIM_HI);
    end
  end

  // stage 3: back-multiply the estimate
  logic [U_W+DIV_W-1:0] qd3_r;
  logic [SQ_W-1:0]      sq3_r;
  logic [U_W-1:0]       q3_r;
  logic                 neg3_r, far3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      qd3_r  <= (U_W+DIV_W)'(q2_r) * (U_W+DIV_W)'(neg2_r ? D_LO : D_HI);
      sq3_r  <= sq2_r;
      q3_r   <= q2_r;
      neg3_r <= neg2_r;
      far3_r <= far2_r;
    end
  end

  // stage 4: correct the quotient, split into table index and fraction
  logic [NUM_W-1:0] rem;
  logic [U_W-1:0]   u;
  logic [AB-1:0]    k4_r;
  logic [FB-1:0]    f4_r;
  logic             far4_r;

  assign rem = {sq3_r, 15'd0} - NUM_W'(qd3_r);
  assign u   = (rem >= NUM_W'(neg3_r ? D_LO : D_HI)) ? q3_r + 1'b1 : q3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      k4_r   <= u[U_W-1:FB];
      f4_r   <= u[FB-1:0];
      far4_r <= far3_r;
    end
  end

  // stage 5: table reads at k and k+1
  logic [30:0]   e0_r, e1_r;
  logic [FB-1:0] f5_r;
  logic          far5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r   <= rom[{1'b0, k4_r}];
      e1_r   <= rom[(AB+1)'({1'b0, k4_r}) + 1'b1];
      f5_r   <= f4_r;
      far5_r <= far4_r;
    end
  end

  // stage 6: linear interpolation, rounded half up
  logic signed [31:0]   sd;
  logic signed [FB+32:0] term;
  logic signed [IW-1:0] ip;
  logic [30:0]          ev6_r;

  assign sd   = $signed({1'b0, e1_r}) - $signed({1'b0, e0_r});
  assign term = sd * $signed({1'b0, f5_r});
  assign ip   = $signed({3'b000, e0_r, {FB{1'b0}}}) + IW'(term) + $signed(HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      ev6_r <= far5_r ? 31'd0 : ip[FB+30:FB];
    end
  end

  // stage 7: apply the lobe weight
  wp_t wp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wp_r <= WEIGHT * $signed({1'b0, ev6_r});
    end
  end

  assign wp = wp_r;

endmodule

@@ src/wlrgb_mix.sv @@
// Lobe sums to XYZ, D65 matrix to linear RGB, clamp, normalize, saturate.
// Depends on wlrgb_pkg.
`timescale 1ns / 1ps

module wlrgb_mix import wlrgb_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   en,
  input  wp_t    wp [NUM_LOBES],
  output color_t red,
  output color_t green,
  output color_t blue
);

  localparam int unsigned SUM_W = WP_W + 2;
  localparam int unsigned XYZ_W = SUM_W - 15;
  localparam int unsigned PR_W  = XYZ_W + 19;
  localparam int unsigned ACC_W = PR_W + 2;
  localparam int unsigned R30_W = ACC_W - 16;
  localparam int unsigned V_W   = R30_W + 18;
  localparam logic [V_W-1:0] RND = V_W'(1) << (45 - OUT_FRAC_BITS);

  // stage 8: lobe sums rounded to Q30, ties away from zero
  logic signed [SUM_W-1:0] cs [3];
  logic [SUM_W-1:0]        mag [3];
  logic [SUM_W-1:0]        rq [3];
  logic signed [XYZ_W-1:0] xyz_r [3];

  assign cs[0] = SUM_W'(wp[0]) + SUM_W'(wp[1]) + SUM_W'(wp[2]);
  assign cs[1] = SUM_W'(wp[3]) + SUM_W'(wp[4]);
  assign cs[2] = SUM_W'(wp[5]) + SUM_W'(wp[6]);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = cs[j][SUM_W-1] ? SUM_W'(-cs[j]) : SUM_W'(cs[j]);
      rq[j]  = (mag[j] + SUM_W'(32768)) >> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        xyz_r[j] <= cs[j][SUM_W-1] ? -$signed(rq[j][XYZ_W-1:0])
                                   : $signed(rq[j][XYZ_W-1:0]);
      end
    end
  end

  // stage 9: matrix products
  logic signed [PR_W-1:0] pr_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[c][j] <= $signed(19'(XYZ_TO_RGB[c][j])) * xyz_r[j];
        end
      end
    end
  end

  // stage 10: row sums, drop negatives, round to Q30
  logic signed [ACC_W-1:0] acc [3];
  logic [R30_W-1:0]        r30_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(pr_r[c][0]) + ACC_W'(pr_r[c][1]) + ACC_W'(pr_r[c][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        r30_r[c] <= acc[c][ACC_W-1] ? '0
                  : R30_W'((ACC_W'(acc[c]) + ACC_W'(32768)) >> 16);
      end
    end
  end

  // stage 11: normalize and saturate into the output register
  logic [V_W-1:0] v [3];
  logic [V_W-1:0] vs [3];
  color_t         col_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v[c]  = V_W'(r30_r[c]) * V_W'(CHAN_RECIP[c]);
      vs[c] = (v[c] + RND) >> (46 - OUT_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        col_r[c] <= (|vs[c][V_W-1:COLOR_W]) ? '1 : vs[c][COLOR_W-1:0];
      end
    end
  end

  assign red   = col_r[0];
  assign green = col_r[1];
  assign blue  = col_r[2];

endmodule

@@ src/wavelength_to_linear_rgb.sv @@
// Top level: wavelength to normalized linear RGB stream pipeline.
// Depends on wlrgb_pkg, wlrgb_if, wlrgb_lobe and wlrgb_mix.
`timescale 1ns / 1ps

// Converts one wavelength word (1/16 nm, clamped to 380..780 nm) into one
// normalized linear RGB word (unsigned, OUT_FRAC_BITS fraction bits,
// saturating at all ones). The datapath is a 12-stage pipeline: an input
// stage, seven stages per Gaussian lobe (seven lobes run side by side) and
// four mixing stages. It takes one word per cycle when the output side is not
// stalled, and each word moves through every stage into the output register.
// The whole pipeline advances together; while a finished word waits at the
// output, every stage holds, so nothing is dropped or repeated, and a new word
// is still taken whenever the output register is empty or being read. The
// block keeps no state between words and needs no configuration.

module wavelength_to_linear_rgb import wlrgb_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS       = OUT_FRAC_BITS_DEF,
  parameter int unsigned EXP_TABLE_ADDR_BITS = EXP_ADDR_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  wlrgb_in_if.sink          in_ch,
  wlrgb_out_if.source       out_ch
);

  localparam int unsigned LAT = 1 + LOBE_LAT + MIX_LAT;

  logic           en;
  logic [LAT-1:0] vld_r, vld_nxt;

  // Advance everything unless a finished word is blocked at the output.
  assign en           = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[LAT-1];

  assign vld_nxt = {vld_r[LAT-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Input stage: clamp to the band, scale to 1/160 nm.
  logic [WL_W-1:0]  wl_c;
  logic [POS_W-1:0] pos_r;

  assign wl_c = (in_ch.wavelength < WL_MIN) ? WL_MIN
              : (in_ch.wavelength > WL_MAX) ? WL_MAX : in_ch.wavelength;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= POS_W'(wl_c) * POS_W'(10);
    end
  end

  // Lobe lanes, all fed by the same position.
  wp_t wp [NUM_LOBES];

  for (genvar i = 0; i < NUM_LOBES; i++) begin : g_lobe
    wlrgb_lobe #(
      .LOBE_IDX            (i),
      .EXP_TABLE_ADDR_BITS (EXP_TABLE_ADDR_BITS)
    ) u_lobe (
      .clk (clk),
      .en  (en),
      .pos (pos_r),
      .wp  (wp[i])
    );
  end

  // Sum lobes, convert to RGB, normalize into the output register.
  wlrgb_mix #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_mix (
    .clk   (clk),
    .en    (en),
    .wp    (wp),
    .red   (out_ch.red),
    .green (out_ch.green),
    .blue  (out_ch.blue)
  );

  // Hold the whole valid chain while stalled.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid chain moved during a stall");

  // An accepted word occupies the first stage next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted word missing from first stage");

  // A word in the last inner stage reaches the output when advancing.
  a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[LAT-2]) |=> out_ch.valid)
    else $error("word lost before the output register");

endmodule
